@@ rtl/core/lru_page_replacement_assert.svh @@
// Assertion macros for the LRU page replacement core.
// Expects clk and arst_n in the scope of use; no other dependencies.
`ifndef LRU_PAGE_REPLACEMENT_ASSERT_SVH
`define LRU_PAGE_REPLACEMENT_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define LRUPR_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked out of reset.
`define LRUPR_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ rtl/core/lrupr_pkg.sv @@
// Shared types and constants for the LRU page replacement core.
// No dependencies.
package lrupr_pkg;

	localparam int FRAME_SLOTS = 16;
	localparam int PAGE_BITS   = 16;
	localparam int SLOT_BITS   = $clog2(FRAME_SLOTS);
	localparam int CNT_BITS    = $clog2(FRAME_SLOTS + 1);
	localparam int CFG_BITS    = 5;
	localparam int TOT_BITS    = 32;

	typedef logic [SLOT_BITS-1:0] slot_t;
	typedef logic [SLOT_BITS-1:0] rank_t;
	typedef logic [CNT_BITS-1:0]  cnt_t;
	typedef logic [PAGE_BITS-1:0] page_t;
	typedef logic [TOT_BITS-1:0]  tot_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_UPDATE
	} scan_state_t;

	// slot table read request
	typedef struct packed {
		logic  en;
		slot_t idx;
	} rd_req_t;

	// registered slot table read data
	typedef struct packed {
		logic  valid;
		rank_t rank;
		page_t page;
	} rd_data_t;

	// make one slot most recent, optionally loading a new page
	typedef struct packed {
		logic  en;
		slot_t slot;
		logic  was_valid;
		rank_t rank;
		logic  page_we;
		page_t page;
	} upd_t;

endpackage

@@ rtl/core/lrupr_store.sv @@
// Slot table: page memory, valid marks and recency ranks, with touch update.
// Depends on lrupr_pkg.
module lrupr_store (
	input  logic               clk,
	input  logic               arst_n,
	input  lrupr_pkg::rd_req_t rd_req,
	output lrupr_pkg::rd_data_t rd_data,
	input  lrupr_pkg::upd_t    upd
);

	lrupr_pkg::page_t page_mem [lrupr_pkg::FRAME_SLOTS];
	logic             valid_q  [lrupr_pkg::FRAME_SLOTS];
	lrupr_pkg::rank_t rank_q   [lrupr_pkg::FRAME_SLOTS];

	// page memory: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (upd.en && upd.page_we) begin
			page_mem[upd.slot] <= upd.page;
		end
		if (rd_req.en) begin
			rd_data.page  <= page_mem[rd_req.idx];
			rd_data.valid <= valid_q[rd_req.idx];
			rd_data.rank  <= rank_q[rd_req.idx];
		end
	end

	// touch: other valid slots age if newer than the touched one (all if it was empty)
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < lrupr_pkg::FRAME_SLOTS; i++) begin
				valid_q[i] <= 1'b0;
				rank_q[i]  <= '0;
			end
		end else if (upd.en) begin
			for (int i = 0; i < lrupr_pkg::FRAME_SLOTS; i++) begin
				if (lrupr_pkg::slot_t'(i) == upd.slot) begin
					valid_q[i] <= 1'b1;
					rank_q[i]  <= '0;
				end else if (valid_q[i] && (!upd.was_valid || rank_q[i] < upd.rank)) begin
					rank_q[i] <= lrupr_pkg::rank_t'(rank_q[i] + 1'b1);
				end
			end
		end
	end

endmodule

@@ rtl/core/lrupr_scan.sv @@
// Sequencer and compare unit: walks the slots in use one per cycle, then
// issues the touch update. Depends on lrupr_pkg and the assertion macros.
`include "lru_page_replacement_assert.svh"

module lrupr_scan (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  lrupr_pkg::page_t    page_in,
	input  lrupr_pkg::cnt_t     n_eff,
	input  logic                out_free,
	output logic                idle,
	output logic                done,
	output logic                res_hit,
	output lrupr_pkg::slot_t    res_slot,
	output lrupr_pkg::rd_req_t  rd_req,
	input  lrupr_pkg::rd_data_t rd_data,
	output lrupr_pkg::upd_t     upd
);

	lrupr_pkg::scan_state_t state_q, state_d;

	lrupr_pkg::page_t page_q;
	lrupr_pkg::cnt_t  cnt_q;
	logic             chk_s1;
	lrupr_pkg::slot_t idx_s1;

	logic             hit_q, emp_q, vic_q;
	lrupr_pkg::slot_t hit_slot_q, emp_slot_q, vic_slot_q;
	lrupr_pkg::rank_t hit_rank_q, vic_rank_q;

	logic match;
	assign match = chk_s1 && rd_data.valid && (rd_data.page == page_q);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			lrupr_pkg::ST_IDLE: begin
				if (start) state_d = lrupr_pkg::ST_SCAN;
			end
			lrupr_pkg::ST_SCAN: begin
				if (match || cnt_q == n_eff) state_d = lrupr_pkg::ST_UPDATE;
			end
			lrupr_pkg::ST_UPDATE: begin
				if (out_free) state_d = lrupr_pkg::ST_IDLE;
			end
			default: state_d = lrupr_pkg::ST_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		idle       = (state_q == lrupr_pkg::ST_IDLE);
		done       = (state_q == lrupr_pkg::ST_UPDATE) && out_free;
		rd_req.en  = (state_q == lrupr_pkg::ST_SCAN) && (cnt_q < n_eff);
		rd_req.idx = cnt_q[lrupr_pkg::SLOT_BITS-1:0];
		res_hit    = hit_q;
		res_slot   = hit_q ? hit_slot_q : (emp_q ? emp_slot_q : vic_slot_q);
		upd.en        = done;
		upd.slot      = res_slot;
		upd.was_valid = hit_q || !emp_q;
		upd.rank      = hit_q ? hit_rank_q : vic_rank_q;
		upd.page_we   = !hit_q;
		upd.page      = page_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= lrupr_pkg::ST_IDLE;
			cnt_q   <= '0;
			chk_s1  <= 1'b0;
			hit_q   <= 1'b0;
			emp_q   <= 1'b0;
			vic_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			chk_s1  <= rd_req.en;
			if (start && idle) begin
				cnt_q <= '0;
				hit_q <= 1'b0;
				emp_q <= 1'b0;
				vic_q <= 1'b0;
			end else if (state_q == lrupr_pkg::ST_SCAN) begin
				if (rd_req.en) cnt_q <= lrupr_pkg::cnt_t'(cnt_q + 1'b1);
				if (chk_s1) begin
					if (rd_data.valid) begin
						if (rd_data.page == page_q) begin
							hit_q <= 1'b1;
						end else if (!vic_q || rd_data.rank > vic_rank_q) begin
							vic_q <= 1'b1;
						end
					end else if (!emp_q) begin
						emp_q <= 1'b1;
					end
				end
			end
		end
	end

	// payload side of the scan tracking
	always_ff @(posedge clk) begin
		if (start && idle) page_q <= page_in;
		if (rd_req.en) idx_s1 <= rd_req.idx;
		if (state_q == lrupr_pkg::ST_SCAN && chk_s1) begin
			if (rd_data.valid) begin
				if (rd_data.page == page_q) begin
					hit_slot_q <= idx_s1;
					hit_rank_q <= rd_data.rank;
				end else if (!vic_q || rd_data.rank > vic_rank_q) begin
					vic_slot_q <= idx_s1;
					vic_rank_q <= rd_data.rank;
				end
			end else if (!emp_q) begin
				emp_slot_q <= idx_s1;
			end
		end
	end

	`LRUPR_ASSERT_NOW(a_rd_in_range, rd_req.en, cnt_q < n_eff, "read beyond slots in use")
	`LRUPR_ASSERT_NOW(a_first_scan, (state_q == lrupr_pkg::ST_SCAN) && !chk_s1,
		cnt_q == '0, "scan pipeline empty after first cycle")
	`LRUPR_ASSERT_NOW(a_victim_found, done && !hit_q && !emp_q, vic_q,
		"miss with no empty slot and no victim")
	`LRUPR_ASSERT_NEXT(a_done_idle, done, state_q == lrupr_pkg::ST_IDLE,
		"sequencer did not return to idle")

endmodule

@@ rtl/core/lru_page_replacement.sv @@
// LRU page replacement top over lrupr_pkg, lrupr_store and lrupr_scan; one reference in flight.
// Per reference: n slot reads, n = frame_count clamped to 1..16, then a read pipeline
// register and an update state; a hit ends the scan early. A new reference is accepted
// only after the previous update, which waits while a result beat is held on out_ready.
// Reset (arst_n low, async): slots empty, totals zero, frame_count = 16.
module lru_page_replacement (
	input  logic                                clk,
	input  logic                                arst_n,
	// configuration: frame_count
	input  logic                                cfg_wr_en,
	input  logic [lrupr_pkg::CFG_BITS-1:0]      cfg_wr_data,
	// page reference beats
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic [lrupr_pkg::PAGE_BITS-1:0]     page,
	// result beats
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic                                hit,
	output logic [3:0]                          frame_index,
	output logic [lrupr_pkg::TOT_BITS-1:0]      hit_total,
	output logic [lrupr_pkg::TOT_BITS-1:0]      fault_total
);

	logic [lrupr_pkg::CFG_BITS-1:0] frame_count_q;
	lrupr_pkg::cnt_t                n_eff;

	lrupr_pkg::tot_t hits_q, faults_q, hits_d, faults_d;

	logic                idle, done, res_hit, out_free, start;
	lrupr_pkg::slot_t    res_slot;
	lrupr_pkg::rd_req_t  rd_req;
	lrupr_pkg::rd_data_t rd_data;
	lrupr_pkg::upd_t     upd;

	// frame_count clamp: 0 behaves as 1, anything above the slot count as the slot count
	always_comb begin
		if (frame_count_q == '0) begin
			n_eff = lrupr_pkg::cnt_t'(1);
		end else if (32'(frame_count_q) > 32'(lrupr_pkg::FRAME_SLOTS)) begin
			n_eff = lrupr_pkg::cnt_t'(lrupr_pkg::FRAME_SLOTS);
		end else begin
			n_eff = lrupr_pkg::cnt_t'(frame_count_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_count_q <= (lrupr_pkg::CFG_BITS)'(lrupr_pkg::FRAME_SLOTS);
		end else if (cfg_wr_en) begin
			frame_count_q <= cfg_wr_data;
		end
	end

	// one reference in flight; the output register lets the next one start
	assign in_ready = idle;
	assign start    = in_valid && in_ready;
	assign out_free = !out_valid || out_ready;

	lrupr_store u_store (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_req  (rd_req),
		.rd_data (rd_data),
		.upd     (upd)
	);

	lrupr_scan u_scan (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.page_in  (page),
		.n_eff    (n_eff),
		.out_free (out_free),
		.idle     (idle),
		.done     (done),
		.res_hit  (res_hit),
		.res_slot (res_slot),
		.rd_req   (rd_req),
		.rd_data  (rd_data),
		.upd      (upd)
	);

	// saturating totals; the result beat carries the post-update values
	always_comb begin
		hits_d   = hits_q;
		faults_d = faults_q;
		if (res_hit) begin
			if (hits_q != '1) hits_d = hits_q + 1'b1;
		end else begin
			if (faults_q != '1) faults_d = faults_q + 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hits_q    <= '0;
			faults_q  <= '0;
			out_valid <= 1'b0;
		end else begin
			if (done) begin
				hits_q    <= hits_d;
				faults_q  <= faults_d;
				out_valid <= 1'b1;
			end else if (out_ready) begin
				out_valid <= 1'b0;
			end
		end
	end

	// output register payload
	always_ff @(posedge clk) begin
		if (done) begin
			hit         <= res_hit;
			frame_index <= 4'(res_slot);
			hit_total   <= hits_d;
			fault_total <= faults_d;
		end
	end

endmodule

@@ verif/tb_lru_page_replacement.sv @@
// Testbench for lru_page_replacement: directed and random page reference beats
// checked against an in-bench LRU predictor with its own copy of the slot table.
// Depends on lrupr_pkg and the lru_page_replacement RTL.
`timescale 1ns / 1ps

module tb_lru_page_replacement;
	import lrupr_pkg::*;

	// one result beat, field for field
	typedef struct packed {
		logic       hit;
		logic [3:0] frame_index;
		tot_t       hit_total;
		tot_t       fault_total;
	} page_result_t;

	localparam int POOL_DEPTH = 24;
	localparam int PHASES     = 12;
	localparam int PHASE_LEN  = 150;
	localparam tot_t TOT_MAX  = '1;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  cfg_wr_en;
	logic [CFG_BITS-1:0]   cfg_wr_data;
	logic                  in_valid;
	logic                  in_ready;
	page_t                 page;
	logic                  out_valid;
	logic                  out_ready = 1'b0;
	logic                  hit;
	logic [3:0]            frame_index;
	tot_t                  hit_total;
	tot_t                  fault_total;

	// predictor state, mirrors the slot table
	logic                  lru_valid [FRAME_SLOTS];
	page_t                 lru_page  [FRAME_SLOTS];
	rank_t                 lru_rank  [FRAME_SLOTS];
	tot_t                  hits_count;
	tot_t                  faults_count;
	logic [CFG_BITS-1:0]   frames_in_use;

	page_result_t          pending_results [$];
	page_t                 page_pool [POOL_DEPTH];
	int                    idle_pct = 10;
	int                    errors   = 0;

	lru_page_replacement dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.page        (page),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.hit         (hit),
		.frame_index (frame_index),
		.hit_total   (hit_total),
		.fault_total (fault_total)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Make slot s most recent. A slot that was already valid only ages the
	// valid slots more recent than it; loading an empty slot ages all valid
	// slots, including those beyond the current frame count.
	function automatic void promote_slot(input int s);
		logic  was_valid;
		rank_t old_rank;
		was_valid = lru_valid[s];
		old_rank  = lru_rank[s];
		for (int i = 0; i < FRAME_SLOTS; i++) begin
			if (i != s && lru_valid[i] && (!was_valid || lru_rank[i] < old_rank))
				lru_rank[i] = lru_rank[i] + 1'b1;
		end
		lru_valid[s] = 1'b1;
		lru_rank[s]  = '0;
	endfunction

	// Look one page up in the slots in use and apply hit or replacement.
	function automatic page_result_t lookup_page(input page_t p);
		int           n;
		int           slot;
		int           empty_slot;
		int           victim;
		bit           found;
		bit           have_empty;
		bit           have_victim;
		page_result_t r;
		// frame count clamps to 1..FRAME_SLOTS
		n = int'(frames_in_use);
		if (n < 1)
			n = 1;
		if (n > FRAME_SLOTS)
			n = FRAME_SLOTS;
		found       = 1'b0;
		have_empty  = 1'b0;
		have_victim = 1'b0;
		slot        = 0;
		empty_slot  = 0;
		victim      = 0;
		// lowest matching slot wins when a page sits in two slots
		for (int i = 0; i < n && !found; i++) begin
			if (lru_valid[i]) begin
				if (lru_page[i] == p) begin
					found = 1'b1;
					slot  = i;
				end else if (!have_victim || lru_rank[i] > lru_rank[victim]) begin
					victim      = i;
					have_victim = 1'b1;
				end
			end else if (!have_empty) begin
				empty_slot = i;
				have_empty = 1'b1;
			end
		end
		if (found) begin
			if (hits_count != TOT_MAX)
				hits_count = hits_count + 1'b1;
			promote_slot(slot);
		end else begin
			slot = have_empty ? empty_slot : victim;
			promote_slot(slot);
			lru_page[slot] = p;
			if (faults_count != TOT_MAX)
				faults_count = faults_count + 1'b1;
		end
		r.hit         = found;
		r.frame_index = slot[3:0];
		r.hit_total   = hits_count;
		r.fault_total = faults_count;
		return r;
	endfunction

	// Receiver side: drop ready about idle_pct cycles in a hundred.
	always @(posedge clk) begin
		out_ready <= ($urandom_range(99) >= idle_pct);
	end

	// Monitor: everything sampled at the edge, so values are the pre-edge ones.
	// Result beats are checked before a same-edge input beat is predicted.
	always @(posedge clk) begin
		page_result_t want;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (pending_results.size() == 0) begin
					$error("result beat with nothing expected");
					errors++;
				end else begin
					want = pending_results.pop_front();
					if (want.hit !== hit) begin
						$error("hit: expected %0d, got %0d", want.hit, hit);
						errors++;
					end
					if (want.frame_index !== frame_index) begin
						$error("frame_index: expected %0d, got %0d",
							want.frame_index, frame_index);
						errors++;
					end
					if (want.hit_total !== hit_total) begin
						$error("hit_total: expected %0d, got %0d",
							want.hit_total, hit_total);
						errors++;
					end
					if (want.fault_total !== fault_total) begin
						$error("fault_total: expected %0d, got %0d",
							want.fault_total, fault_total);
						errors++;
					end
				end
			end
			if (in_valid && in_ready)
				pending_results.push_back(lookup_page(page));
			if (cfg_wr_en)
				frames_in_use = cfg_wr_data;
		end
	end

	// Send one page beat. valid is lowered only when a gap is taken, so it
	// never drops and rises within one step between back-to-back beats.
	task automatic send_page(input page_t p);
		while ($urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		page     <= p;
		do @(posedge clk); while (!in_ready);
	endtask

	// Stop sending and wait until every expected result beat has come back.
	task automatic wait_for_results();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (2) @(posedge clk);
	endtask

	// Register write only with the block idle.
	task automatic set_frame_count(input logic [CFG_BITS-1:0] value);
		wait_for_results();
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= value;
		@(posedge clk);
		cfg_wr_en   <= 1'b0;
		@(posedge clk);
	endtask

	// Reset frame count (16): fill empty slots in order, extreme page values,
	// then hits on resident pages.
	task automatic test_fill_and_hit();
		send_page(16'h0000);
		send_page(16'hFFFF);
		send_page(16'h5555);
		send_page(16'hAAAA);
		send_page(16'h0000);
		send_page(16'hFFFF);
	endtask

	// Shrink to two slots: replacement only among them while slots beyond keep
	// their pages; grow back so a page is resident twice and the lower slot hits.
	task automatic test_shrink_and_regrow();
		set_frame_count(5'd2);
		send_page(16'h1234);
		send_page(16'h5555);
		set_frame_count(5'd16);
		send_page(16'h5555);
		send_page(16'h1234);
	endtask

	// Out-of-range counts: zero acts as one slot, above the slot total acts as all.
	task automatic test_count_clamp();
		set_frame_count(5'd0);
		send_page(16'hAAAA);
		send_page(16'hAAAA);
		send_page(16'h8001);
		set_frame_count(5'd31);
		send_page(16'h0000);
		send_page(16'h7FFE);
	endtask

	// Phases over several frame counts. Most pages come from a small pool
	// sized near the slots in use, so hits, evictions and refills all occur;
	// the rest are fully random. One phase runs with no idling on either side,
	// and each phase pauses mid-way until every result has drained.
	task automatic test_random_traffic();
		int          fc_list [PHASES];
		int          used;
		int          pool_size;
		int          refresh;
		page_t       p;
		fc_list = '{16, 1, 4, 2, 31, 8, 0, 3, 15, 17, 5, 16};
		for (int k = 0; k < POOL_DEPTH; k++)
			page_pool[k] = page_t'($urandom);
		for (int ph = 0; ph < PHASES; ph++) begin
			if (ph == 10)
				fc_list[ph] = $urandom_range(0, 31);
			set_frame_count(CFG_BITS'(fc_list[ph]));
			idle_pct = (ph == 5) ? 0 : 10;
			used = fc_list[ph];
			if (used < 1)
				used = 1;
			if (used > FRAME_SLOTS)
				used = FRAME_SLOTS;
			pool_size = used + $urandom_range(0, 4);
			if (pool_size > POOL_DEPTH)
				pool_size = POOL_DEPTH;
			// keep most of the pool so pages left in idle slots come back
			refresh = $urandom_range(1, 8);
			for (int k = 0; k < refresh; k++)
				page_pool[$urandom_range(0, POOL_DEPTH - 1)] = page_t'($urandom);
			for (int i = 0; i < PHASE_LEN; i++) begin
				if (i == PHASE_LEN / 2)
					wait_for_results();
				if ($urandom_range(99) < 80)
					p = page_pool[$urandom_range(0, pool_size - 1)];
				else
					p = page_t'($urandom);
				send_page(p);
			end
		end
		idle_pct = 10;
	endtask

	// Watchdog, far above the slowest legal run.
	initial begin
		#10_000_000;
		$display("end of test: mismatches");
		$finish;
	end

	initial begin
		// all inputs known from time zero, reset held low before release
		arst_n      = 1'b0;
		cfg_wr_en   = 1'b0;
		cfg_wr_data = '0;
		in_valid    = 1'b0;
		page        = '0;
		for (int i = 0; i < FRAME_SLOTS; i++) begin
			lru_valid[i] = 1'b0;
			lru_page[i]  = '0;
			lru_rank[i]  = '0;
		end
		hits_count    = '0;
		faults_count  = '0;
		frames_in_use = CFG_BITS'(FRAME_SLOTS);
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		test_fill_and_hit();
		test_shrink_and_regrow();
		test_count_clamp();
		test_random_traffic();

		// drain, then wait for any stray beat to show up
		wait_for_results();
		repeat (60) @(posedge clk);
		if (errors == 0 && pending_results.size() == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

endmodule
